// ===== hdl/vertex_project_to_screen_assert.svh =====
// Assertion macros for the vertex projection block.
// Included by modules that check their own control logic.
`ifndef VERTEX_PROJECT_TO_SCREEN_ASSERT_SVH
`define VERTEX_PROJECT_TO_SCREEN_ASSERT_SVH
`ifndef SYNTHESIS
// Implication checked every clock edge outside reset.
`define VPS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Signal must never be unknown outside reset.
`define VPS_KNOWN(label, clk, rst_n, sig, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !$isunknown(sig)) \
	else $error(msg);
`else
`define VPS_ASSERT(label, clk, rst_n, prop, msg)
`define VPS_KNOWN(label, clk, rst_n, sig, msg)
`endif
`endif

// ===== hdl/vps_pkg.sv =====
// Package for the vertex projection block: widths, fixed-point helpers, command types.
// No dependencies.
package vps_pkg;
	localparam int FRAC_BITS = 16;
	localparam int QW = 32;
	localparam int SLOTS = 24;
	localparam int IDXW = 5;
	localparam logic signed [QW-1:0] QMAX = {1'b0, {(QW-1){1'b1}}};
	localparam logic signed [QW-1:0] QMIN = {1'b1, {(QW-1){1'b0}}};
	localparam logic signed [QW-1:0] ONE_Q = QW'(1) <<< FRAC_BITS;

	// register map
	localparam logic [1:0] ADDR_MODE = 2'd0;

	// input item functions
	localparam logic FUNC_COEF    = 1'b0;
	localparam logic FUNC_PROJECT = 1'b1;

	// ALU operations
	localparam logic [2:0] OP_MUL  = 3'd0;
	localparam logic [2:0] OP_ADD  = 3'd1;
	localparam logic [2:0] OP_SUB  = 3'd2;
	localparam logic [2:0] OP_HADD = 3'd3; // b + half(a)
	localparam logic [2:0] OP_HSUB = 3'd4; // b - half(a)
	localparam logic [2:0] OP_RCP  = 3'd5; // start reciprocal

	// operand sources
	localparam logic [1:0] SRC_REG = 2'd0;
	localparam logic [1:0] SRC_TAB = 2'd1;

	typedef struct packed {
		logic        go;
		logic [2:0]  op;
		logic [3:0]  ra;   // register file index for a
		logic [1:0]  bsrc;
		logic [3:0]  rb;
		logic [IDXW-1:0] tb;
		logic [3:0]  rd;
		logic        load_in;
		logic        clr_err;
	} dp_cmd_t;

	typedef struct packed {
		logic busy;
	} dp_sts_t;

	function automatic logic signed [QW-1:0] sat_add(input logic signed [QW-1:0] a,
		input logic signed [QW-1:0] b, output logic ovf);
		logic signed [QW:0] s;
		begin
			s = {a[QW-1], a} + {b[QW-1], b};
			ovf = s[QW] != s[QW-1];
			sat_add = ovf ? (s[QW] ? QMIN : QMAX) : s[QW-1:0];
		end
	endfunction

	function automatic logic signed [QW-1:0] sat_sub(input logic signed [QW-1:0] a,
		input logic signed [QW-1:0] b, output logic ovf);
		logic signed [QW:0] s;
		begin
			s = {a[QW-1], a} - {b[QW-1], b};
			ovf = s[QW] != s[QW-1];
			sat_sub = ovf ? (s[QW] ? QMIN : QMAX) : s[QW-1:0];
		end
	endfunction

	// rounding half: ties toward +inf
	function automatic logic signed [QW-1:0] qhalf(input logic signed [QW-1:0] v);
		logic signed [QW:0] t;
		begin
			t = {v[QW-1], v} + (QW+1)'(1);
			qhalf = t[QW:1];
		end
	endfunction
endpackage

// ===== hdl/vps_if.sv =====
// Valid/ready channel interfaces for vertex projection items.
// Depends on vps_pkg.
interface vps_in_if import vps_pkg::*; ();
	logic valid;
	logic ready;
	logic func;
	logic [IDXW-1:0] coef_index;
	logic signed [QW-1:0] coef_value;
	logic signed [QW-1:0] obj_x;
	logic signed [QW-1:0] obj_y;
	logic signed [QW-1:0] obj_z;
	modport source(output valid, func, coef_index, coef_value, obj_x, obj_y, obj_z,
		input ready);
	modport sink(input valid, func, coef_index, coef_value, obj_x, obj_y, obj_z,
		output ready);
endinterface

interface vps_out_if import vps_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [QW-1:0] screen_x;
	logic signed [QW-1:0] screen_y;
	logic signed [QW-1:0] screen_depth;
	logic range_error;
	modport source(output valid, screen_x, screen_y, screen_depth, range_error,
		input ready);
	modport sink(input valid, screen_x, screen_y, screen_depth, range_error,
		output ready);
endinterface

// ===== hdl/vps_datapath.sv =====
// Datapath: coefficient table, register file, multiplier, adder, reciprocal divider.
// Depends on vps_pkg.
module vps_datapath import vps_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  dp_cmd_t cmd,
	output dp_sts_t sts,
	input  logic tab_we,
	input  logic [IDXW-1:0] tab_idx,
	input  logic signed [QW-1:0] tab_wdata,
	input  logic signed [QW-1:0] in_x,
	input  logic signed [QW-1:0] in_y,
	input  logic signed [QW-1:0] in_z,
	output logic signed [QW-1:0] rf_x,
	output logic signed [QW-1:0] rf_y,
	output logic signed [QW-1:0] rf_z,
	output logic err
);
	logic signed [QW-1:0] tab_q [SLOTS];
	logic signed [QW-1:0] rf_q [16];
	logic err_q;
	logic signed [QW-1:0] a, b;
	logic signed [QW-1:0] res;
	logic res_ovf;

	// multiplier
	logic [QW-1:0] ua, ub;
	logic [2*QW-1:0] prod, prnd;
	logic [2*QW-FRAC_BITS-1:0] mag;
	logic mneg;
	logic [QW:0] lim;

	// reciprocal divider: restoring, one quotient bit a cycle
	localparam int NB = 2*FRAC_BITS + 2;
	localparam int CW = $clog2(NB+1);
	logic [NB-1:0] num_q;
	logic [QW:0] rem_q;
	logic [QW-1:0] den_q;
	logic [NB-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic rbusy_q, rneg_q, rzero_q;
	logic [3:0] rd_q;
	logic [QW:0] rtry;
	logic [NB:0] qr;
	logic [QW:0] rlim;

	always_comb begin
		a = rf_q[cmd.ra];
		b = (cmd.bsrc == SRC_TAB) ? tab_q[cmd.tb] : rf_q[cmd.rb];
		ua = a[QW-1] ? QW'(-a) : QW'(a);
		ub = b[QW-1] ? QW'(-b) : QW'(b);
		mneg = a[QW-1] ^ b[QW-1];
		prod = ua * ub;
		prnd = prod + ((2*QW)'(1) << (FRAC_BITS-1));
		mag = prnd[2*QW-1:FRAC_BITS];
		lim = mneg ? (QW+1)'(1) << (QW-1) : (QW+1)'(QMAX);
		res = '0;
		res_ovf = 1'b0;
		unique case (cmd.op)
			OP_MUL: begin
				if (mag > (2*QW-FRAC_BITS)'(lim)) begin
					res_ovf = 1'b1;
					res = mneg ? QMIN : QMAX;
				end else begin
					res = mneg ? -QW'(mag) : QW'(mag);
				end
			end
			OP_ADD: res = sat_add(a, b, res_ovf);
			OP_SUB: res = sat_sub(a, b, res_ovf);
			OP_HADD: res = sat_add(b, qhalf(a), res_ovf);
			OP_HSUB: res = sat_sub(b, qhalf(a), res_ovf);
			default: res = a;
		endcase
	end

	always_comb begin
		rtry = {rem_q[QW-1:0], num_q[NB-1]} - {1'b0, den_q};
		qr = {1'b0, quo_q} + (NB+1)'(1);
		rlim = rneg_q ? (QW+1)'(1) << (QW-1) : (QW+1)'(QMAX);
	end

	assign sts.busy = rbusy_q;

	always_ff @(posedge clk) begin
		if (tab_we) tab_q[tab_idx] <= tab_wdata;
		if (cmd.load_in) begin
			rf_q[0] <= in_x;
			rf_q[1] <= in_y;
			rf_q[2] <= in_z;
			rf_q[15] <= ONE_Q;
		end
		if (cmd.go && cmd.op != OP_RCP) rf_q[cmd.rd] <= res;
		if (cmd.go && cmd.op == OP_RCP) begin
			num_q <= NB'(1) << (2*FRAC_BITS+1);   // 2*2^(2F): rounding via extra bit
			rem_q <= '0;
			den_q <= ua;
			quo_q <= '0;
			rneg_q <= ~a[QW-1];
			rzero_q <= (a == '0);
			rd_q <= cmd.rd;
		end else if (rbusy_q && cnt_q != '0) begin
			num_q <= num_q << 1;
			if (!rtry[QW]) begin
				rem_q <= rtry;
				quo_q <= {quo_q[NB-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[QW-1:0], num_q[NB-1]};
				quo_q <= {quo_q[NB-2:0], 1'b0};
			end
		end else if (rbusy_q) begin
			// quo = floor(2^(2F+1)/d); rounded = (quo+1)>>1
			if (rzero_q) rf_q[rd_q] <= QMIN;
			else if (qr[NB:1] > NB'(rlim)) rf_q[rd_q] <= rneg_q ? QMIN : QMAX;
			else rf_q[rd_q] <= rneg_q ? -QW'(qr[NB:1]) : QW'(qr[NB:1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rbusy_q <= 1'b0;
			cnt_q <= '0;
			err_q <= 1'b0;
		end else begin
			if (cmd.go && cmd.op == OP_RCP) begin
				rbusy_q <= 1'b1;
				cnt_q <= CW'(NB);
			end else if (rbusy_q && cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
			end else if (rbusy_q) begin
				rbusy_q <= 1'b0;
				if (rzero_q || qr[NB:1] > NB'(rlim)) err_q <= 1'b1;
			end
			if (cmd.clr_err) err_q <= 1'b0;
			else if (cmd.go && cmd.op != OP_RCP && res_ovf) err_q <= 1'b1;
		end
	end

	assign rf_x = rf_q[12];
	assign rf_y = rf_q[13];
	assign rf_z = rf_q[14];
	assign err = err_q;
endmodule

// ===== hdl/vps_ctrl.sv =====
// Sequencer for the projection: steps a micro-program over the shared datapath.
// Depends on vps_pkg and the assertion header.
`include "vertex_project_to_screen_assert.svh"
module vps_ctrl import vps_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic persp,
	input  dp_sts_t sts,
	output dp_cmd_t cmd,
	output logic busy,
	output logic done
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;
	localparam int NSTEP = 25;
	localparam int SW = 5;

	logic [1:0] state_q;
	logic [SW-1:0] pc_q;
	logic persp_q;
	dp_cmd_t step;

	// registers: 0-2 in, 3-5 eye, 6-8 clip xyz, 9 w, 10-11 temp, 12-14 out, 15 one
	function automatic dp_cmd_t mk(input logic [2:0] op, input logic [3:0] ra,
		input logic [1:0] bs, input logic [3:0] rb, input logic [IDXW-1:0] tb,
		input logic [3:0] rd);
		dp_cmd_t c;
		begin
			c = '0;
			c.go = 1'b1; c.op = op; c.ra = ra; c.bsrc = bs; c.rb = rb; c.tb = tb; c.rd = rd;
			mk = c;
		end
	endfunction

	always_comb begin
		step = '0;
		unique case (pc_q)
			5'd0:  step = mk(OP_MUL, 4'd0, SRC_TAB, 4'd0, 5'd0, 4'd10);
			5'd1:  step = mk(OP_MUL, 4'd1, SRC_TAB, 4'd0, 5'd1, 4'd11);
			5'd2:  step = mk(OP_ADD, 4'd10, SRC_REG, 4'd11, 5'd0, 4'd10);
			5'd3:  step = mk(OP_MUL, 4'd2, SRC_TAB, 4'd0, 5'd2, 4'd11);
			5'd4:  step = mk(OP_ADD, 4'd10, SRC_REG, 4'd11, 5'd0, 4'd10);
			5'd5:  step = mk(OP_ADD, 4'd10, SRC_TAB, 4'd0, 5'd3, 4'd3);
			5'd6:  step = mk(OP_MUL, 4'd0, SRC_TAB, 4'd0, 5'd4, 4'd10);
			5'd7:  step = mk(OP_MUL, 4'd1, SRC_TAB, 4'd0, 5'd5, 4'd11);
			5'd8:  step = mk(OP_ADD, 4'd10, SRC_REG, 4'd11, 5'd0, 4'd10);
			5'd9:  step = mk(OP_MUL, 4'd2, SRC_TAB, 4'd0, 5'd6, 4'd11);
			5'd10: step = mk(OP_ADD, 4'd10, SRC_REG, 4'd11, 5'd0, 4'd10);
			5'd11: step = mk(OP_ADD, 4'd10, SRC_TAB, 4'd0, 5'd7, 4'd4);
			5'd12: step = mk(OP_MUL, 4'd0, SRC_TAB, 4'd0, 5'd8, 4'd10);
			5'd13: step = mk(OP_MUL, 4'd1, SRC_TAB, 4'd0, 5'd9, 4'd11);
			5'd14: step = mk(OP_ADD, 4'd10, SRC_REG, 4'd11, 5'd0, 4'd10);
			5'd15: step = mk(OP_MUL, 4'd2, SRC_TAB, 4'd0, 5'd10, 4'd11);
			5'd16: step = mk(OP_ADD, 4'd10, SRC_REG, 4'd11, 5'd0, 4'd10);
			5'd17: step = mk(OP_ADD, 4'd10, SRC_TAB, 4'd0, 5'd11, 4'd5);
			5'd18: step = mk(OP_MUL, 4'd3, SRC_TAB, 4'd0, 5'd12, 4'd6);
			5'd19: step = persp_q ? mk(OP_MUL, 4'd5, SRC_TAB, 4'd0, 5'd13, 4'd10)
				: mk(OP_ADD, 4'd6, SRC_TAB, 4'd0, 5'd13, 4'd6);
			5'd20: step = persp_q ? mk(OP_ADD, 4'd6, SRC_REG, 4'd10, 5'd0, 4'd6)
				: mk(OP_MUL, 4'd4, SRC_TAB, 4'd0, 5'd14, 4'd7);
			5'd21: step = persp_q ? mk(OP_MUL, 4'd4, SRC_TAB, 4'd0, 5'd14, 4'd7)
				: mk(OP_ADD, 4'd7, SRC_TAB, 4'd0, 5'd15, 4'd7);
			5'd22: step = persp_q ? mk(OP_MUL, 4'd5, SRC_TAB, 4'd0, 5'd15, 4'd10)
				: mk(OP_MUL, 4'd5, SRC_TAB, 4'd0, 5'd16, 4'd8);
			5'd23: step = persp_q ? mk(OP_ADD, 4'd7, SRC_REG, 4'd10, 5'd0, 4'd7)
				: mk(OP_ADD, 4'd8, SRC_TAB, 4'd0, 5'd17, 4'd8);
			default: step = '0;
		endcase
	end

	// tail program: indexed by its own counter tpc_q in a second bank
	dp_cmd_t tail;
	logic [SW-1:0] tpc_q;
	logic in_tail_q;
	localparam int NTAIL = 19;
	always_comb begin
		tail = '0;
		unique case (tpc_q)
			5'd0:  tail = mk(OP_MUL, 4'd5, SRC_TAB, 4'd0, 5'd16, 4'd8);
			5'd1:  tail = mk(OP_ADD, 4'd8, SRC_TAB, 4'd0, 5'd17, 4'd8);
			5'd2:  tail = persp_q ? mk(OP_RCP, 4'd5, SRC_REG, 4'd0, 5'd0, 4'd9)
				: mk(OP_MUL, 4'd15, SRC_REG, 4'd15, 5'd0, 4'd9); // w = one * one
			5'd3:  tail = mk(OP_MUL, 4'd9, SRC_REG, 4'd6, 5'd0, 4'd10);
			5'd4:  tail = mk(OP_MUL, 4'd10, SRC_TAB, 4'd0, 5'd20, 4'd10);
			5'd5:  tail = mk(OP_ADD, 4'd10, SRC_TAB, 4'd0, 5'd20, 4'd10);
			5'd6:  tail = mk(OP_HADD, 4'd10, SRC_TAB, 4'd0, 5'd18, 4'd12);
			5'd7:  tail = mk(OP_MUL, 4'd9, SRC_REG, 4'd7, 5'd0, 4'd10);
			5'd8:  tail = mk(OP_MUL, 4'd10, SRC_TAB, 4'd0, 5'd21, 4'd10);
			5'd9:  tail = mk(OP_SUB, 4'd10, SRC_TAB, 4'd0, 5'd21, 4'd10);
			5'd10: tail = mk(OP_HSUB, 4'd10, SRC_TAB, 4'd0, 5'd19, 4'd13);
			5'd11: tail = mk(OP_MUL, 4'd9, SRC_REG, 4'd8, 5'd0, 4'd10);
			5'd12: tail = mk(OP_MUL, 4'd15, SRC_TAB, 4'd0, 5'd23, 4'd11);
			5'd13: tail = mk(OP_SUB, 4'd11, SRC_TAB, 4'd0, 5'd22, 4'd11);
			5'd14: tail = mk(OP_MUL, 4'd10, SRC_REG, 4'd11, 5'd0, 4'd10);
			5'd15: tail = mk(OP_MUL, 4'd15, SRC_TAB, 4'd0, 5'd23, 4'd11);
			5'd16: tail = mk(OP_ADD, 4'd11, SRC_REG, 4'd10, 5'd0, 4'd14);
			default: tail = '0;
		endcase
	end

	always_comb begin
		cmd = '0;
		if (state_q == ST_RUN) cmd = in_tail_q ? tail : step;
		if (start) begin
			cmd.load_in = 1'b1;
			cmd.clr_err = 1'b1;
		end
	end

	assign busy = state_q != ST_IDLE;
	assign done = state_q == ST_DONE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q <= '0;
			tpc_q <= '0;
			in_tail_q <= 1'b0;
			persp_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_RUN;
						pc_q <= '0;
						tpc_q <= '0;
						in_tail_q <= 1'b0;
						persp_q <= persp;
					end
				end
				ST_RUN: begin
					if (!in_tail_q) begin
						if (pc_q == SW'(NSTEP-1) - SW'(1)) begin
							in_tail_q <= 1'b1;
							// orthographic already made z in steps 22,23
							tpc_q <= persp_q ? '0 : 5'd2;
						end else pc_q <= pc_q + SW'(1);
					end else if (tail.op == OP_RCP && persp_q) begin
						state_q <= ST_WAIT;
						tpc_q <= tpc_q + SW'(1);
					end else if (tpc_q == SW'(NTAIL-3)) begin
						state_q <= ST_DONE;
					end else tpc_q <= tpc_q + SW'(1);
				end
				ST_WAIT: if (!sts.busy) state_q <= ST_RUN;
				ST_DONE: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`VPS_ASSERT(a_start_idle, clk, arst_n, start |-> state_q == ST_IDLE, "start while busy")
	`VPS_ASSERT(a_done_idle, clk, arst_n, done |=> state_q == ST_IDLE, "done not followed by idle")
	`VPS_ASSERT(a_wait_div, clk, arst_n, (state_q == ST_WAIT) |-> persp_q, "divide in ortho")
	`VPS_KNOWN(a_state_known, clk, arst_n, state_q, "state unknown")
endmodule

// ===== hdl/vertex_project_to_screen.sv =====
// Top level of the vertex projection block: APB register, input/output channels.
// Depends on vps_pkg, vps_if, vps_ctrl, vps_datapath.
//
// Usage:
//  - Input channel (vps_in_if): func 0 writes coef_value into table slot coef_index
//    (slots 24..31 ignored) and gives no result. func 1 projects obj_x/y/z;
//    exactly one result item follows on the output channel.
//  - Every table slot used must be written before a projection reads it.
//  - APB register 0 (byte address 0): perspective_mode, reset 1.
//  - In perspective mode the sequencer waits on the bit-serial reciprocal divider
//    (one quotient bit a cycle). All products share one 32x32 multiplier and one
//    adder, so one vertex is in flight at a time; the next item is taken only
//    once the result has left the output register.
//  - The output register holds the result while ready is low; the sequencer
//    starts no new vertex until that register is free.
//  - Reset (arst_n low) clears control state and sets perspective mode; the
//    coefficient table is not cleared.
//  - range_error is set for zero eye depth in perspective mode or any saturated step.
module vertex_project_to_screen import vps_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	vps_in_if.sink in_ch,
	vps_out_if.source out_ch,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	logic persp_q;
	logic start, busy, done, err;
	logic out_valid_q;
	dp_cmd_t cmd;
	dp_sts_t sts;
	logic signed [QW-1:0] rx, ry, rz;
	logic accept;

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_MODE) ? {31'd0, persp_q} : 32'd0;

	// take items only when the sequencer is free and the output register is empty
	assign in_ch.ready = !busy && !out_valid_q;
	assign accept = in_ch.valid && in_ch.ready;
	assign start = accept && in_ch.func == FUNC_PROJECT;

	vps_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .persp(persp_q), .sts(sts),
		.cmd(cmd), .busy(busy), .done(done)
	);

	vps_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.tab_we(accept && in_ch.func == FUNC_COEF && in_ch.coef_index < IDXW'(SLOTS)),
		.tab_idx(in_ch.coef_index), .tab_wdata(in_ch.coef_value),
		.in_x(in_ch.obj_x), .in_y(in_ch.obj_y), .in_z(in_ch.obj_z),
		.rf_x(rx), .rf_y(ry), .rf_z(rz), .err(err)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			persp_q <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (psel && penable && pwrite && paddr == ADDR_MODE) persp_q <= pwdata[0];
			if (done) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (done) begin
			out_ch.screen_x <= rx;
			out_ch.screen_y <= ry;
			out_ch.screen_depth <= rz;
			out_ch.range_error <= err;
		end
	end
	assign out_ch.valid = out_valid_q;
endmodule
